@@ hdl/eapm_pkg.sv @@
package eapm_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int STAGES = 30;
	localparam int CW = 33;
	localparam int PW = 64;
	localparam int EW = 18;
	localparam int TW = 32;

	typedef logic signed [CW-1:0] q30_t;

	typedef struct packed {
		logic signed [TW-1:0] sz;
		logic signed [TW-1:0] sy;
		logic signed [TW-1:0] sx;
	} shift_t;

	localparam logic [CW-1:0] GAIN_Q30 = CW'(32'h26DD3B6A);
	localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1 <<< 30);

	function automatic logic [CW-1:0] step_angle(input int i);
		logic [31:0] t [STAGES];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
		return CW'(t[i]);
	endfunction

	function automatic q30_t clamp30(input q30_t v);
		if (v > ONE_Q30)
			return ONE_Q30;
		if (v < -ONE_Q30)
			return -ONE_Q30;
		return v;
	endfunction

	function automatic logic [EW-1:0] coef_out(input logic signed [PW-1:0] q60);
		logic signed [PW-1:0] v;
		logic signed [PW-1:0] lim;
		lim = PW'(64'sd1 <<< COEF_FRAC_BITS);
		v = (q60 + (PW'(64'sd1) <<< (59 - COEF_FRAC_BITS))) >>> (60 - COEF_FRAC_BITS);
		if (v > lim)
			v = lim;
		else if (v < -lim)
			v = -lim;
		return v[EW-1:0];
	endfunction
endpackage

@@ hdl/euler_angles_to_pose_matrix_top.sv @@
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | angle_x, angle_y, angle_z, shift_x, shift_y, shift_z (144 bits)
// m_axis  | out | r00..r22 (18 b each), out_x, out_y, out_z (264 bits)
// One word per cycle unless m_axis stalls; 31 CORDIC stages, 5 matrix stages.
// Depth set by the 30-iteration CORDIC pipeline, fully unrolled, plus the matrix stages.
// arst_n clears valid bits only.
// A stall on m_axis freezes the whole pipeline; s_axis_tready falls with it.
module euler_angles_to_pose_matrix_top
	import eapm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // angle_x, angle_y, angle_z, shift_x, shift_y, shift_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [263:0] m_axis_tdata   // r00..r22, out_x, out_y, out_z
);
	localparam int LAT = STAGES + 1 + 5;

	logic en;
	logic [LAT-1:0] vld_q;
	shift_t sh_s [LAT];
	q30_t cx, sx, cy, sy, cz, sz;
	logic [9*EW-1:0] ent;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en)
			sh_s[0] <= s_axis_tdata[143:48];
	end
	for (genvar i = 0; i < LAT - 1; i++) begin : g_sh
		always_ff @(posedge clk) begin
			if (en)
				sh_s[i+1] <= sh_s[i];
		end
	end

	eapm_cordic u_cx (.clk, .en, .angle(s_axis_tdata[15:0]), .cos_v(cx), .sin_v(sx));
	eapm_cordic u_cy (.clk, .en, .angle(s_axis_tdata[31:16]), .cos_v(cy), .sin_v(sy));
	eapm_cordic u_cz (.clk, .en, .angle(s_axis_tdata[47:32]), .cos_v(cz), .sin_v(sz));

	eapm_matrix u_mat (.clk, .en, .cx, .sx, .cy, .sy, .cz, .sz, .ent);

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = {6'b0, sh_s[LAT-1].sz, sh_s[LAT-1].sy, sh_s[LAT-1].sx, ent};

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && en |=> vld_q[1])
		else $error("valid lost");
`endif
endmodule

@@ hdl/eapm_cordic.sv @@
module eapm_cordic
	import eapm_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output q30_t                  cos_v,
	output q30_t                  sin_v
);
	logic [1:0] quad_s [STAGES+1];
	q30_t x_s [STAGES+1];
	q30_t y_s [STAGES+1];
	q30_t z_s [STAGES+1];
	logic [31:0] phase;

	assign phase = 32'(angle) << (32 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[0] <= phase[31:30];
			x_s[0] <= GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= CW'(phase[29:0]);
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i+1] <= quad_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - step_angle(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + step_angle(i);
				end
			end
		end
	end

	q30_t xc, yc;
	assign xc = clamp30(x_s[STAGES]);
	assign yc = clamp30(y_s[STAGES]);

	always_comb begin
		unique case (quad_s[STAGES])
			2'd0: begin cos_v = xc; sin_v = yc; end
			2'd1: begin cos_v = -yc; sin_v = xc; end
			2'd2: begin cos_v = -xc; sin_v = -yc; end
			default: begin cos_v = yc; sin_v = -xc; end
		endcase
	end
endmodule

@@ hdl/eapm_matrix.sv @@
module eapm_matrix
	import eapm_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  q30_t              cx,
	input  q30_t              sx,
	input  q30_t              cy,
	input  q30_t              sy,
	input  q30_t              cz,
	input  q30_t              sz,
	output logic [9*EW-1:0]   ent
);
	typedef logic signed [PW-1:0] p_t;
	q30_t cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	p_t czsy_s2, szsy_s2, czcy_s2, szcy_s2, cycx_s2, cysx_s2;
	p_t szcx_s2, szsx_s2, czcx_s2, czsx_s2, nsy_s2;
	q30_t cx_s2, sx_s2;
	q30_t a_s3, b_s3, cx_s3, sx_s3;
	p_t czcy_s3, szcy_s3, cycx_s3, cysx_s3, szcx_s3, szsx_s3, czcx_s3, czsx_s3, nsy_s3;
	p_t t01_s4, t02_s4, t11_s4, t12_s4;
	p_t czcy_s4, szcy_s4, cycx_s4, cysx_s4, szcx_s4, szsx_s4, czcx_s4, czsx_s4, nsy_s4;
	logic [9*EW-1:0] ent_s5;

	function automatic q30_t rnd30(input p_t v);
		p_t r;
		r = (v + (p_t'(1) <<< 29)) >>> 30;
		return r[CW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= cx; sx_s1 <= sx; cy_s1 <= cy;
			sy_s1 <= sy; cz_s1 <= cz; sz_s1 <= sz;
			czsy_s2 <= p_t'(cz_s1) * p_t'(sy_s1);
			szsy_s2 <= p_t'(sz_s1) * p_t'(sy_s1);
			czcy_s2 <= p_t'(cz_s1) * p_t'(cy_s1);
			szcy_s2 <= p_t'(sz_s1) * p_t'(cy_s1);
			cycx_s2 <= p_t'(cy_s1) * p_t'(cx_s1);
			cysx_s2 <= p_t'(cy_s1) * p_t'(sx_s1);
			szcx_s2 <= p_t'(sz_s1) * p_t'(cx_s1);
			szsx_s2 <= p_t'(sz_s1) * p_t'(sx_s1);
			czcx_s2 <= p_t'(cz_s1) * p_t'(cx_s1);
			czsx_s2 <= p_t'(cz_s1) * p_t'(sx_s1);
			nsy_s2 <= -(p_t'(sy_s1) <<< 30);
			cx_s2 <= cx_s1; sx_s2 <= sx_s1;
			a_s3 <= rnd30(czsy_s2); b_s3 <= rnd30(szsy_s2);
			cx_s3 <= cx_s2; sx_s3 <= sx_s2;
			czcy_s3 <= czcy_s2; szcy_s3 <= szcy_s2; cycx_s3 <= cycx_s2;
			cysx_s3 <= cysx_s2; szcx_s3 <= szcx_s2; szsx_s3 <= szsx_s2;
			czcx_s3 <= czcx_s2; czsx_s3 <= czsx_s2; nsy_s3 <= nsy_s2;
			t01_s4 <= p_t'(a_s3) * p_t'(sx_s3);
			t02_s4 <= p_t'(a_s3) * p_t'(cx_s3);
			t11_s4 <= p_t'(b_s3) * p_t'(sx_s3);
			t12_s4 <= p_t'(b_s3) * p_t'(cx_s3);
			czcy_s4 <= czcy_s3; szcy_s4 <= szcy_s3; cycx_s4 <= cycx_s3;
			cysx_s4 <= cysx_s3; szcx_s4 <= szcx_s3; szsx_s4 <= szsx_s3;
			czcx_s4 <= czcx_s3; czsx_s4 <= czsx_s3; nsy_s4 <= nsy_s3;
			ent_s5 <= {coef_out(cycx_s4), coef_out(cysx_s4), coef_out(nsy_s4),
				coef_out(t12_s4 - czsx_s4), coef_out(t11_s4 + czcx_s4), coef_out(szcy_s4),
				coef_out(t02_s4 + szsx_s4), coef_out(t01_s4 - szcx_s4), coef_out(czcy_s4)};
		end
	end

	assign ent = ent_s5;
endmodule
